FILE: hdl/lsa_pkg.sv
package lsa_pkg;

  localparam int SEED_W    = 63;
  localparam int FRAC_W    = 24;
  localparam int FRAC_LSB  = SEED_W - FRAC_W;
  localparam int SKIP_BITS = 63;
  localparam int BIDX_W    = 6;
  localparam int LO_W      = 32;
  localparam int MID_W     = SEED_W - LO_W;
  localparam int CFG_ADDR_W = 1;

  localparam logic [SEED_W-1:0] MULT_RESET = 63'd2806196910506780709;
  localparam logic [SEED_W-1:0] INCR_RESET = 63'd1;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_MULTIPLIER = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INCREMENT  = 1'b1;

  typedef struct packed {
    logic [SEED_W-1:0] start_seed;
    logic [SEED_W-1:0] skip_count;
  } lsa_req_t;

  typedef struct packed {
    logic [SEED_W-1:0] jumped_seed;
    logic [SEED_W-1:0] stepped_seed;
    logic [FRAC_W-1:0] sample_fraction;
  } lsa_rsp_t;

  typedef struct packed {
    logic              valid;
    logic [SEED_W-1:0] x;
    logic [SEED_W-1:0] tag;
  } lsa_stage_t;

endpackage

FILE: hdl/lsa_mul.sv
module lsa_mul import lsa_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SEED_W-1:0] a,
  input  logic [SEED_W-1:0] b,
  output logic [SEED_W-1:0] prod
);

  // Product modulo 2^63 from three 32-bit partial products; the high-by-high
  // term lands at bit 64 and drops out entirely. The cross terms are only
  // needed below bit 31, so their low operand bits alone decide them.
  logic [SEED_W-1:0] ll_full;
  logic [MID_W-1:0]  lh_full;
  logic [MID_W-1:0]  hl_full;
  logic [SEED_W-1:0] p_ll;
  logic [MID_W-1:0]  p_lh;
  logic [MID_W-1:0]  p_hl;
  logic [MID_W-1:0]  mid;

  assign ll_full = SEED_W'(a[LO_W-1:0]) * SEED_W'(b[LO_W-1:0]);
  assign lh_full = a[MID_W-1:0] * b[SEED_W-1:LO_W];
  assign hl_full = a[SEED_W-1:LO_W] * b[MID_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      p_ll <= ll_full;
      p_lh <= lh_full;
      p_hl <= hl_full;
    end
  end

  assign mid  = p_lh + p_hl;
  assign prod = p_ll + {mid, {LO_W{1'b0}}};

endmodule

FILE: hdl/lsa_jump_stage.sv
module lsa_jump_stage import lsa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  lsa_stage_t        in_stage,
  input  logic              take,
  input  logic [SEED_W-1:0] coef_a,
  input  logic [SEED_W-1:0] coef_c,
  output lsa_stage_t        out_stage
);

  logic              v1;
  logic              take1;
  logic [SEED_W-1:0] x1;
  logic [SEED_W-1:0] tag1;
  logic              v2;
  logic [SEED_W-1:0] x2;
  logic [SEED_W-1:0] tag2;
  logic [SEED_W-1:0] prod;

  lsa_mul u_mul (
    .clk  (clk),
    .en   (en),
    .a    (in_stage.x),
    .b    (coef_a),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_stage.valid;
      v2 <= v1;
    end
  end

  // The affine step is applied only when this stage's count bit is set.
  always_ff @(posedge clk) begin
    if (en) begin
      take1 <= take;
      x1    <= in_stage.x;
      tag1  <= in_stage.tag;
      x2    <= take1 ? (prod + coef_c) : x1;
      tag2  <= tag1;
    end
  end

  assign out_stage = '{valid: v2, x: x2, tag: tag2};

endmodule

FILE: hdl/lsa_table.sv
module lsa_table import lsa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [SEED_W-1:0]     cfg_wdata,
  output logic [SEED_W-1:0]     mult_val,
  output logic [SEED_W-1:0]     incr_val,
  output logic [SEED_W-1:0]     coef_a [SKIP_BITS],
  output logic [SEED_W-1:0]     coef_c [SKIP_BITS],
  output logic                  busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_SUM  = 2'd3;

  logic [1:0]        state;
  logic [BIDX_W-1:0] bidx;
  logic [SEED_W-1:0] sa;
  logic [SEED_W-1:0] sc;
  logic [SEED_W-1:0] sa_plus1;
  logic [SEED_W-1:0] prod_a;
  logic [SEED_W-1:0] prod_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      mult_val <= MULT_RESET;
      incr_val <= INCR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MULTIPLIER: mult_val <= cfg_wdata;
        CFG_INCREMENT:  incr_val <= cfg_wdata;
      endcase
    end
  end

  // Entry k holds the coefficients of the map applied 2^k times:
  // a' = a*a and c' = c*(a+1) from one entry to the next.
  assign sa_plus1 = sa + {{(SEED_W-1){1'b0}}, 1'b1};

  lsa_mul u_mul_a (
    .clk  (clk),
    .en   (1'b1),
    .a    (sa),
    .b    (sa),
    .prod (prod_a)
  );

  lsa_mul u_mul_c (
    .clk  (clk),
    .en   (1'b1),
    .a    (sc),
    .b    (sa_plus1),
    .prod (prod_c)
  );

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_LOAD;
      bidx  <= '0;
    end else begin
      unique case (state)
        S_IDLE: state <= S_IDLE;
        S_LOAD: begin
          state <= S_MUL;
          bidx  <= {{(BIDX_W-1){1'b0}}, 1'b1};
        end
        S_MUL: state <= S_SUM;
        S_SUM: begin
          if (bidx == BIDX_W'(SKIP_BITS - 1)) begin
            state <= S_IDLE;
          end else begin
            state <= S_MUL;
            bidx  <= bidx + {{(BIDX_W-1){1'b0}}, 1'b1};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      sa        <= mult_val;
      sc        <= incr_val;
      coef_a[0] <= mult_val;
      coef_c[0] <= incr_val;
    end else if (state == S_SUM) begin
      sa           <= prod_a;
      sc           <= prod_c;
      coef_a[bidx] <= prod_a;
      coef_c[bidx] <= prod_c;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: hdl/lcg_skip_ahead_core.sv
// Pipeline: 63 jump stages (one per skip bit), one step stage, the output register.
// Throughput: one transaction per cycle while req_stall is low, set by the fully
// pipelined 32-bit partial product multipliers in every stage.
// Reset: multiplier and increment take their defaults; after reset and after each
// configuration write the power table is rebuilt with req_stall high.
module lcg_skip_ahead_core import lsa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  lsa_req_t              req_data,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output lsa_rsp_t              rsp_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [SEED_W-1:0]     cfg_wdata
);

  logic              en;
  logic              busy;
  logic [SEED_W-1:0] mult_val;
  logic [SEED_W-1:0] incr_val;
  logic [SEED_W-1:0] coef_a [SKIP_BITS];
  logic [SEED_W-1:0] coef_c [SKIP_BITS];
  lsa_stage_t        chain [SKIP_BITS+1];
  lsa_stage_t        step_in;
  lsa_stage_t        step_out;
  logic              arrive;
  lsa_rsp_t          arrive_data;
  logic              spare_valid;
  lsa_rsp_t          spare_data;

  lsa_table u_table (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .mult_val  (mult_val),
    .incr_val  (incr_val),
    .coef_a    (coef_a),
    .coef_c    (coef_c),
    .busy      (busy)
  );

  // The whole pipeline moves together; the spare register absorbs the one
  // transaction that can still arrive after the output stalls.
  assign en        = !spare_valid;
  assign req_stall = busy || spare_valid;

  assign chain[0] = '{valid: req_valid && !req_stall,
                      x:     req_data.start_seed,
                      tag:   req_data.skip_count};

  for (genvar k = 0; k < SKIP_BITS; k++) begin : g_jump
    lsa_jump_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_stage  (chain[k]),
      .take      (chain[k].tag[k]),
      .coef_a    (coef_a[k]),
      .coef_c    (coef_c[k]),
      .out_stage (chain[k+1])
    );
  end

  // The final ordinary step carries the jumped seed along in the tag field.
  assign step_in = '{valid: chain[SKIP_BITS].valid,
                     x:     chain[SKIP_BITS].x,
                     tag:   chain[SKIP_BITS].x};

  lsa_jump_stage u_step (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_stage  (step_in),
    .take      (1'b1),
    .coef_a    (mult_val),
    .coef_c    (incr_val),
    .out_stage (step_out)
  );

  assign arrive      = en && step_out.valid;
  assign arrive_data = '{jumped_seed:     step_out.tag,
                         stepped_seed:    step_out.x,
                         sample_fraction: step_out.x[SEED_W-1:FRAC_LSB]};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      if (spare_valid) begin
        rsp_valid   <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        rsp_valid <= arrive;
      end
    end else if (arrive) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || !rsp_stall) begin
      rsp_data <= spare_valid ? spare_data : arrive_data;
    end else if (arrive) begin
      spare_data <= arrive_data;
    end
  end

`ifndef SYNTH
  a_spare_needs_out: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> rsp_valid)
    else $error("spare register holds a transaction while the output is empty");

  a_spare_blocks_req: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> req_stall)
    else $error("request accepted while the spare register is full");

  a_spare_drains: assert property (@(posedge clk) disable iff (rst)
    spare_valid && !rsp_stall |=> rsp_valid && !spare_valid)
    else $error("spare register did not drain into the output");

  a_busy_blocks_req: assert property (@(posedge clk) disable iff (rst)
    busy |-> req_stall)
    else $error("request accepted during the table rebuild");
`endif

endmodule
